@@ hdl/sensor_frame_check_convert_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sensor frame check and convert unit
// Concurrent checks on clock, disabled during reset; empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CHECK_CONVERT_UNIT_MACROS_SVH
`define SENSOR_FRAME_CHECK_CONVERT_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SFCC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SFCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SFCC_ASSERT_NOW(label, ante, cons, msg)
`define SFCC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ hdl/sfcc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfcc_pkg
// Shared types, constants and the CRC-8 step for the frame check/convert unit.
// ----------------------------------------------------------------------------
package sfcc_pkg;

   // Default depth of the frame queue between front and back
   localparam int unsigned SFCC_QUEUE_DEPTH = 4;

   // CRC-8, polynomial x^8+x^5+x^4+1, no reflection, no final xor
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Fixed-point conversion constants
   localparam logic [14:0]        TEMP_SCALE   = 15'd17500;
   localparam logic [13:0]        HUM_SCALE    = 14'd10000;
   localparam logic signed [15:0] TEMP_BIAS    = 16'sd4500;
   localparam logic signed [11:0] OFFSET_RESET = -12'sd400;

   // Byte positions inside a frame
   localparam logic [2:0] POS_T_HIGH  = 3'd0;
   localparam logic [2:0] POS_T_LOW   = 3'd1;
   localparam logic [2:0] POS_T_CHECK = 3'd2;
   localparam logic [2:0] POS_H_HIGH  = 3'd3;
   localparam logic [2:0] POS_H_CHECK = 3'd5;

   typedef enum logic {
      MODE_MEASURE  = 1'b0,
      MODE_IDENTITY = 1'b1
   } frame_mode_type;

   typedef enum logic {
      CSR_FRAME_MODE  = 1'b0,
      CSR_TEMP_OFFSET = 1'b1
   } csr_index_type;

   // One finished frame, as handed from front to back
   typedef struct packed {
      frame_mode_type mode;
      logic           failed;
      logic [15:0]    first_word;
      logic [15:0]    second_word;
   } frame_rec_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // One byte through the CRC register, MSB first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

@@ hdl/sfcc_front.sv @@
// ----------------------------------------------------------------------------
// sfcc_front
// Tracks byte position, runs the CRC, collects data words and queues a
// record when the last byte of a frame arrives.
// ----------------------------------------------------------------------------
module sfcc_front
   import sfcc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_rx_byte,
   input  logic             req_frame_start,
   input  frame_mode_type   frame_mode,
   input  queue_status_type q_status,
   output logic             push,
   output frame_rec_type    push_rec
);

   logic [2:0]  pos_ff,    pos_in;
   logic [7:0]  crc_ff,    crc_in;
   logic [7:0]  high_ff,   high_in;
   logic [7:0]  low_ff,    low_in;
   logic [15:0] first_ff,  first_in;
   logic        failed_ff, failed_in;

   logic       accept;
   logic [2:0] pos;
   logic       failed_base;
   logic       is_check;
   logic       is_last;
   logic       failed_now;

   // Only a full queue holds the byte stream back
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // Classify the byte
   always_comb begin
      pos         = req_frame_start ? POS_T_HIGH : pos_ff;
      failed_base = req_frame_start ? 1'b0 : failed_ff;
      if (frame_mode == MODE_IDENTITY) begin
         is_check = (pos >= POS_T_CHECK);
         is_last  = is_check;
      end else begin
         is_check = (pos == POS_T_CHECK) || (pos == POS_H_CHECK);
         is_last  = (pos == POS_H_CHECK);
      end
      failed_now = failed_base || (is_check && (crc_ff != req_rx_byte));
   end

   // Next state
   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      first_in  = first_ff;
      failed_in = failed_ff;
      if (accept) begin
         if (!is_check) begin
            if (pos == POS_T_HIGH || pos == POS_H_HIGH) begin
               crc_in  = crc8_update(CRC_INIT, req_rx_byte);
               high_in = req_rx_byte;
            end else begin
               crc_in = crc8_update(crc_ff, req_rx_byte);
               if (pos == POS_T_LOW) begin
                  first_in = {high_ff, req_rx_byte};
               end else begin
                  low_in = req_rx_byte;
               end
            end
         end
         if (is_last) begin
            pos_in    = POS_T_HIGH;
            failed_in = 1'b0;
         end else begin
            pos_in    = pos + 3'd1;
            failed_in = failed_now;
         end
      end
   end

   // Record for the back end
   assign push                 = accept && is_last;
   assign push_rec.mode        = frame_mode;
   assign push_rec.failed      = failed_now;
   assign push_rec.first_word  = first_ff;
   assign push_rec.second_word = {high_ff, low_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_T_HIGH;
         crc_ff    <= CRC_INIT;
         high_ff   <= 8'd0;
         low_ff    <= 8'd0;
         first_ff  <= 16'd0;
         failed_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
         first_ff  <= first_in;
         failed_ff <= failed_in;
      end
   end

endmodule

@@ hdl/sfcc_queue.sv @@
// ----------------------------------------------------------------------------
// sfcc_queue
// Small FIFO of finished frame records between front and back.
// ----------------------------------------------------------------------------
`include "sensor_frame_check_convert_unit_macros.svh"

module sfcc_queue
   import sfcc_pkg::*;
#(
   parameter int unsigned DEPTH = SFCC_QUEUE_DEPTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frame_rec_type    push_rec,
   input  logic             pop,
   output frame_rec_type    pop_rec,
   output queue_status_type q_status
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   frame_rec_type entry_ff [DEPTH];

   logic [PTR_W-1:0] head_ff,  head_in;
   logic [PTR_W-1:0] tail_ff,  tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_status.full      = (count_ff == CNT_W'(DEPTH));
   assign q_status.not_empty = (count_ff != '0);
   assign pop_rec            = entry_ff[head_ff];

   // Pointer and fill count update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_rec;
      end
   end

   `SFCC_ASSERT_NOW(a_no_overflow, push, !q_status.full || pop, "queue push while full")
   `SFCC_ASSERT_NOW(a_no_underflow, pop, q_status.not_empty, "queue pop while empty")
   `SFCC_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + CNT_W'(1), "queue count did not rise")
   `SFCC_ASSERT_NEXT(a_count_down, pop && !push, count_ff == $past(count_ff) - CNT_W'(1), "queue count did not fall")

endmodule

@@ hdl/sfcc_back.sv @@
// ----------------------------------------------------------------------------
// sfcc_back
// Converts queued frame records: a multiply stage, then an output register
// that adds bias and offset and selects fields by mode and check status.
// ----------------------------------------------------------------------------
module sfcc_back
   import sfcc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  queue_status_type    q_status,
   output logic                pop,
   input  frame_rec_type       pop_rec,
   input  logic signed [11:0]  temp_offset,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [14:0]  rsp_temperature_centi,
   output logic [13:0]         rsp_humidity_centi,
   output logic [15:0]         rsp_id_word,
   output logic                rsp_status
);

   logic out_en;
   logic mul_en;

   // Multiply stage
   logic           mul_valid_ff, mul_valid_in;
   logic [30:0]    prod_t_ff;
   logic [29:0]    prod_h_ff;
   logic [15:0]    id_ff;
   frame_mode_type mode_ff;
   logic           failed_ff;

   // Output stage
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [14:0] temp_ff;
   logic [13:0]        hum_ff;
   logic [15:0]        id_out_ff;
   logic               status_ff;

   logic signed [15:0] temp_sum;
   logic signed [14:0] temp_sel;
   logic [13:0]        hum_sel;
   logic [15:0]        id_sel;

   // Stage enables: each stage loads when its successor is free
   assign out_en = !rsp_valid_ff || !rsp_stall;
   assign mul_en = !mul_valid_ff || out_en;
   assign pop    = mul_en && q_status.not_empty;

   assign mul_valid_in = mul_en ? q_status.not_empty : mul_valid_ff;
   assign rsp_valid_in = out_en ? mul_valid_ff : rsp_valid_ff;

   // Bias, offset and field selection
   always_comb begin
      temp_sum = $signed({1'b0, prod_t_ff[30:16]}) - TEMP_BIAS
               + $signed({{4{temp_offset[11]}}, temp_offset});
      temp_sel = '0;
      hum_sel  = '0;
      id_sel   = '0;
      if (!failed_ff) begin
         if (mode_ff == MODE_IDENTITY) begin
            id_sel = id_ff;
         end else begin
            temp_sel = temp_sum[14:0];
            hum_sel  = prod_h_ff[29:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Multiply stage payload
   always_ff @(posedge clock) begin
      if (pop) begin
         prod_t_ff <= 31'(pop_rec.first_word) * 31'(TEMP_SCALE);
         prod_h_ff <= 30'(pop_rec.second_word) * 30'(HUM_SCALE);
         id_ff     <= pop_rec.first_word;
         mode_ff   <= pop_rec.mode;
         failed_ff <= pop_rec.failed;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (out_en && mul_valid_ff) begin
         temp_ff   <= temp_sel;
         hum_ff    <= hum_sel;
         id_out_ff <= id_sel;
         status_ff <= failed_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = temp_ff;
   assign rsp_humidity_centi    = hum_ff;
   assign rsp_id_word           = id_out_ff;
   assign rsp_status            = status_ff;

endmodule

@@ hdl/sensor_frame_check_convert_unit.sv @@
// ----------------------------------------------------------------------------
// sensor_frame_check_convert_unit
// CRC-checked humidity/temperature frame decoder with configuration registers.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; one result per six-byte (measurement) or
//   three-byte (identity) frame; a full frame queue is the only input stall.
// Path: the record for the closing check byte is queued, then moves through the
//   multiply stage into the output register; a receiver stall can hold it there.
// Reset: synchronous, clears position, CRC, queue and valids; mode measurement,
//   offset -4.00 degrees.
module sensor_frame_check_convert_unit
   import sfcc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = SFCC_QUEUE_DEPTH
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi,
   output logic [15:0]        rsp_id_word,
   output logic               rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [11:0]        csr_wdata
);

   frame_mode_type     frame_mode_ff,  frame_mode_in;
   logic signed [11:0] temp_offset_ff, temp_offset_in;

   queue_status_type q_status;
   logic             push;
   logic             pop;
   frame_rec_type    push_rec;
   frame_rec_type    pop_rec;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      frame_mode_in  = frame_mode_ff;
      temp_offset_in = temp_offset_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_MODE:  frame_mode_in  = frame_mode_type'(csr_wdata[0]);
            CSR_TEMP_OFFSET: temp_offset_in = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_mode_ff  <= MODE_MEASURE;
         temp_offset_ff <= OFFSET_RESET;
      end else begin
         frame_mode_ff  <= frame_mode_in;
         temp_offset_ff <= temp_offset_in;
      end
   end

   sfcc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .frame_mode      (frame_mode_ff),
      .q_status        (q_status),
      .push            (push),
      .push_rec        (push_rec)
   );

   sfcc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .q_status (q_status)
   );

   sfcc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_status              (q_status),
      .pop                   (pop),
      .pop_rec               (pop_rec),
      .temp_offset           (temp_offset_ff),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_id_word           (rsp_id_word),
      .rsp_status            (rsp_status)
   );

endmodule

@@ tb/sv/tb_sensor_frame_check_convert_unit.sv @@
// ----------------------------------------------------------------------------
// tb_sensor_frame_check_convert_unit
// Self-checking bench for the sensor frame check/convert unit. A byte-level
// model tracks frame position, CRC-8 and the conversions for every accepted
// request. Each result is compared field by field against that prediction.
// Traffic is a directed set of frames and corner cases, then random phases
// under changing settings, random stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_sensor_frame_check_convert_unit
   import sfcc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF      = 6;
   localparam int RESET_CYCLES    = 5;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_CYCLES     = 300;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 175;
   localparam int TIMEOUT_NS      = 10_000_000;

   // One converted frame as seen on the result port
   typedef struct packed {
      logic signed [14:0] temperature;
      logic [13:0]        humidity;
      logic [15:0]        id;
      logic               status;
   } frame_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               req_frame_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [14:0] rsp_temperature_centi;
   logic [13:0]        rsp_humidity_centi;
   logic [15:0]        rsp_id_word;
   logic               rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   csr_index_type      csr_index = CSR_FRAME_MODE;
   logic [11:0]        csr_wdata = 12'h000;

   // Predicted configuration and frame state
   frame_mode_type     mode_cfg;
   logic signed [11:0] offset_cfg;
   logic [2:0]         frame_pos;
   logic [7:0]         frame_crc;
   logic [7:0]         held_high;
   logic [7:0]         held_low;
   logic [15:0]        word0;
   logic               frame_bad;

   frame_result_type   expected_frames[$];
   int                 error_count = 0;
   int                 send_idle_pct = 0;
   int                 rsp_stall_pct = 0;
   int                 hold_cycles_req = 0;

   sensor_frame_check_convert_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .req_frame_start       (req_frame_start),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_id_word           (rsp_id_word),
      .rsp_status            (rsp_status),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // CRC-8 over one byte, one bit at a time, MSB first
   function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      logic       fb;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[7] ^ data[i];
         r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   function automatic logic [7:0] word_check(input logic [15:0] w);
      return crc_next(crc_next(CRC_INIT, w[15:8]), w[7:0]);
   endfunction

   // Mostly short idle stretches, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(1, 100);
      if (r <= 80) return $urandom_range(1, 3);
      if (r <= 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_word();
      int r;
      r = $urandom_range(1, 20);
      if (r == 1) return 16'h0000;
      if (r == 2) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // Advance the frame model by one accepted byte; queue a result on the last byte
   task automatic decode_byte(input logic [7:0] b, input logic fs);
      logic [2:0]       p;
      bit               is_check;
      bit               is_last;
      frame_result_type r;
      int               t;
      int               h;
      if (fs) begin
         frame_pos = 3'd0;
         frame_bad = 1'b0;
      end
      p = frame_pos;
      if (mode_cfg == MODE_IDENTITY) begin
         is_check = (p >= POS_T_CHECK);
         is_last  = is_check;
      end else begin
         is_check = (p == POS_T_CHECK) || (p == POS_H_CHECK);
         is_last  = (p == POS_H_CHECK);
      end
      if (is_check) begin
         if (frame_crc != b) frame_bad = 1'b1;
      end else begin
         // high bytes restart the CRC for their group
         if (p == POS_T_HIGH || p == POS_H_HIGH) begin
            frame_crc = crc_next(CRC_INIT, b);
            held_high = b;
         end else begin
            frame_crc = crc_next(frame_crc, b);
            if (p == POS_T_LOW) word0 = {held_high, b};
            else held_low = b;
         end
      end
      if (!is_last) begin
         frame_pos = p + 3'd1;
      end else begin
         frame_pos = 3'd0;
         r = '0;
         r.status = frame_bad;
         if (!frame_bad) begin
            if (mode_cfg == MODE_IDENTITY) begin
               r.id = word0;
            end else begin
               t = ((17500 * int'(word0)) >> 16) - 4500 + int'(offset_cfg);
               h = (10000 * int'({held_high, held_low})) >> 16;
               r.temperature = t[14:0];
               r.humidity    = h[13:0];
            end
         end
         expected_frames.push_back(r);
         frame_bad = 1'b0;
      end
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // Model update on every accepted request
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) decode_byte(req_rx_byte, req_frame_start);
   end

   // Register writes go into the model at the handshake
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == CSR_FRAME_MODE) mode_cfg = frame_mode_type'(csr_wdata[0]);
         else offset_cfg = csr_wdata;
      end
   end

   // Result checker
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual temp %0d hum %0d id %0d st %0d",
                     $time, rsp_temperature_centi, rsp_humidity_centi, rsp_id_word, rsp_status);
            error_count++;
         end else begin
            want = expected_frames.pop_front();
            check_field("temperature", int'($signed(want.temperature)),
                        int'($signed(rsp_temperature_centi)));
            check_field("humidity", int'(want.humidity), int'(rsp_humidity_centi));
            check_field("id_word", int'(want.id), int'(rsp_id_word));
            check_field("status", int'(want.status), int'(rsp_status));
         end
      end
   end

   // Receiver stalls: random short/long stretches, or one long hold on demand
   initial begin
      int len;
      forever begin
         @(negedge clock);
         if (hold_cycles_req > 0) begin
            len = hold_cycles_req;
            hold_cycles_req = 0;
            rsp_stall <= 1'b1;
            repeat (len) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(1, 100) <= rsp_stall_pct) begin
            len = idle_len();
            rsp_stall <= 1'b1;
            repeat (len) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one request and hold it until taken; maybe idle afterwards
   task automatic send_request(input logic [7:0] b, input logic fs);
      int gap;
      req_rx_byte     <= b;
      req_frame_start <= fs;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if ($urandom_range(1, 100) <= send_idle_pct) begin
         gap = idle_len();
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Send the first 'cut' bytes of a frame sized for the current mode
   task automatic send_frame(input logic [15:0] w0, input logic [15:0] w1, input bit bad0,
                             input bit bad1, input bit restart, input int cut);
      logic [7:0] bytes[6];
      int         len;
      len = (mode_cfg == MODE_IDENTITY) ? 3 : 6;
      bytes[0] = w0[15:8];
      bytes[1] = w0[7:0];
      bytes[2] = word_check(w0) ^ (bad0 ? 8'($urandom_range(1, 255)) : 8'h00);
      bytes[3] = w1[15:8];
      bytes[4] = w1[7:0];
      bytes[5] = word_check(w1) ^ (bad1 ? 8'($urandom_range(1, 255)) : 8'h00);
      for (int i = 0; i < len && i < cut; i++) send_request(bytes[i], (i == 0) ? restart : 1'b0);
   endtask

   // Drop valid, let all results come back, then give the pipe time to settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [11:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input frame_mode_type m, input logic signed [11:0] off);
      wait_idle();
      write_register(CSR_FRAME_MODE, {11'($urandom), m});
      write_register(CSR_TEMP_OFFSET, off);
   endtask

   // Measurement frames at reset settings: field extremes and a failed check
   task automatic test_measure_frames();
      send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1, 6);
      send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b1, 6);
   endtask

   // Identity frames: good one, then a bad one that continues without a start flag
   task automatic test_identity_frames();
      set_config(MODE_IDENTITY, 12'sd2000);
      send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1, 3);
      send_frame(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 3);
   endtask

   // Frame restart mid-frame, then mode switch while a measurement frame is open
   task automatic test_restart_and_mode_switch();
      logic [15:0] w0;
      logic [15:0] w1;
      send_request(8'h5A, 1'b1);
      send_frame(16'hA5C3, 16'h0000, 1'b0, 1'b0, 1'b1, 3);
      set_config(MODE_MEASURE, -12'sd2000);
      w0 = pick_word();
      w1 = pick_word();
      send_frame(w0, w1, 1'b0, 1'b0, 1'b1, 4);
      wait_idle();
      write_register(CSR_FRAME_MODE, {11'd0, MODE_IDENTITY});
      // position 4 now closes the frame as its check byte
      send_request(crc_next(CRC_INIT, w1[15:8]), 1'b0);
   endtask

   // Long receiver hold while the sender keeps pushing, so the input side stalls
   task automatic test_backpressure();
      set_config(MODE_MEASURE, -12'sd400);
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      hold_cycles_req = HOLD_CYCLES;
      repeat (12) send_frame(pick_word(), pick_word(), 1'b0, 1'b0, 1'b1, 6);
      wait_idle();
   endtask

   // Random phases: mostly well-formed frames, some cut short, some stray bytes
   task automatic test_random_frames();
      int             sent;
      int             r;
      int             len;
      int             cut;
      int             off;
      frame_mode_type m;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       begin off = -2000; m = MODE_MEASURE;  end
            1:       begin off = 2000;  m = MODE_IDENTITY; end
            2:       begin off = 0;     m = MODE_MEASURE;  end
            3:       begin off = -2000; m = MODE_IDENTITY; end
            default: begin
               off = $urandom_range(0, 4000) - 2000;
               m   = frame_mode_type'($urandom_range(0, 1));
            end
         endcase
         set_config(m, 12'(off));
         case (phase % 4)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 20; rsp_stall_pct = 20; end
            2:       begin send_idle_pct = 50; rsp_stall_pct = 40; end
            default: begin send_idle_pct = 10; rsp_stall_pct = 60; end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            r   = $urandom_range(1, 100);
            len = (mode_cfg == MODE_IDENTITY) ? 3 : 6;
            if (r <= 75) begin
               send_frame(pick_word(), pick_word(), $urandom_range(1, 10) == 1,
                          $urandom_range(1, 10) == 1, $urandom_range(1, 10) != 1, len);
               sent += len;
            end else if (r <= 88) begin
               cut = $urandom_range(1, len - 1);
               send_frame(pick_word(), pick_word(), 1'b0, 1'b0, 1'b1, cut);
               sent += cut;
            end else begin
               send_request(8'($urandom), 1'($urandom));
               sent++;
            end
         end
      end
   endtask

   initial begin
      // model starts from the reset state
      mode_cfg   = MODE_MEASURE;
      offset_cfg = -12'sd400;
      frame_pos  = 3'd0;
      frame_crc  = CRC_INIT;
      held_high  = 8'h00;
      held_low   = 8'h00;
      word0      = 16'h0000;
      frame_bad  = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_measure_frames();
      test_identity_frames();
      test_restart_and_mode_switch();
      test_backpressure();
      test_random_frames();
      wait_idle();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule
